// ----- rtl/wsfe_pkg.sv -----
// Package for the WebSocket frame encoder: queue entry type, item kinds and
// framing constants. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wsfe_pkg;

  // Depth of the queue between front and back. Must be a power of two.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned LEN_W  = 63;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned IDX_W  = 4;

  localparam logic [LEN_W-1:0] LEN_SHORT_MAX = LEN_W'(125);
  localparam logic [LEN_W-1:0] LEN_MED_MAX   = LEN_W'(65535);

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic       MASK_BIT    = 1'b1;

  // Byte index of the first key byte and of the last length byte per header kind.
  localparam logic [IDX_W-1:0] KEY_START_SHORT = IDX_W'(2);
  localparam logic [IDX_W-1:0] KEY_START_MED   = IDX_W'(4);
  localparam logic [IDX_W-1:0] KEY_START_LONG  = IDX_W'(10);
  localparam logic [IDX_W-1:0] LEN_LAST_MED    = IDX_W'(3);
  localparam logic [IDX_W-1:0] LEN_LAST_LONG   = IDX_W'(9);
  localparam logic [IDX_W-1:0] IDX_FIRST       = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_LEN_CODE    = IDX_W'(1);
  localparam logic [IDX_W-1:0] KEY_LAST_OFS    = IDX_W'(3);

  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    KIND_SHORT = 2'd0,
    KIND_MED   = 2'd1,
    KIND_LONG  = 2'd2,
    KIND_DATA  = 2'd3
  } kind_e;

  // One queued item: its kind, its first byte (FIN/opcode or data) and the length.
  typedef struct packed {
    kind_e            kind;
    logic [7:0]       first;
    logic [LEN_W-1:0] len;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/wsfe_front.sv -----
// Front end of the frame encoder: accepts input items and classifies them
// into queue entries. Depends on wsfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsfe_front
  import wsfe_pkg::*;
(
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             op_i,
  input  wire logic             fin_i,
  input  wire logic [3:0]       frame_opcode_i,
  input  wire logic [LEN_W-1:0] payload_length_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.len = payload_length_i;
    if (op_i == OP_PAYLOAD) begin
      cmd_o.kind  = KIND_DATA;
      cmd_o.first = data_byte_i;
    end else begin
      cmd_o.first = {fin_i, 3'b000, frame_opcode_i};
      if (payload_length_i <= LEN_SHORT_MAX) begin
        cmd_o.kind = KIND_SHORT;
      end else if (payload_length_i <= LEN_MED_MAX) begin
        cmd_o.kind = KIND_MED;
      end else begin
        cmd_o.kind = KIND_LONG;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wsfe_queue.sv -----
// Short queue of classified items between front and back of the encoder.
// Depends on wsfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsfe_queue
  import wsfe_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      head_valid_o,
  output cmd_t      head_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wsfe_back.sv -----
// Back end of the encoder: walks the head queue entry byte by byte, applies
// the mask key and drives the output register. Depends on wsfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsfe_back
  import wsfe_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic [KEY_W-1:0] cfg_mask_key_i,
  input  wire logic             head_valid_i,
  input  cmd_t                  head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_of_run_o
);

  logic [KEY_W-1:0] mask_key_q;
  logic [1:0]       mask_pos_q, mask_pos_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q;
  logic             out_last_q;

  logic             load;
  logic [7:0]       byte_c;
  logic             last_c;
  logic [IDX_W-1:0] key_start;
  logic [IDX_W-1:0] len_last;
  logic [IDX_W-1:0] key_ofs;
  logic [IDX_W-1:0] len_sel;
  logic [1:0]       key_sel;
  logic [7:0]       key_byte;
  logic [7:0]       len_byte;
  logic [6:0]       len_code;
  logic [LEN_W:0]   len_ext;

  // Key byte 0 is the most significant byte, as it goes out on the wire.
  always_comb begin
    case (key_sel)
      2'd0:    key_byte = mask_key_q[31:24];
      2'd1:    key_byte = mask_key_q[23:16];
      2'd2:    key_byte = mask_key_q[15:8];
      default: key_byte = mask_key_q[7:0];
    endcase
  end

  always_comb begin
    len_ext = {1'b0, head_i.len};
    case (len_sel[2:0])
      3'd0:    len_byte = len_ext[7:0];
      3'd1:    len_byte = len_ext[15:8];
      3'd2:    len_byte = len_ext[23:16];
      3'd3:    len_byte = len_ext[31:24];
      3'd4:    len_byte = len_ext[39:32];
      3'd5:    len_byte = len_ext[47:40];
      3'd6:    len_byte = len_ext[55:48];
      default: len_byte = len_ext[63:56];
    endcase
  end

  always_comb begin
    case (head_i.kind)
      KIND_SHORT: begin
        key_start = KEY_START_SHORT;
        len_last  = LEN_LAST_MED;
        len_code  = head_i.len[6:0];
      end
      KIND_MED: begin
        key_start = KEY_START_MED;
        len_last  = LEN_LAST_MED;
        len_code  = LEN_CODE_16;
      end
      default: begin
        key_start = KEY_START_LONG;
        len_last  = LEN_LAST_LONG;
        len_code  = LEN_CODE_64;
      end
    endcase
    key_ofs = idx_q - key_start;
    len_sel = len_last - idx_q;

    if (head_i.kind == KIND_DATA) begin
      key_sel = mask_pos_q;
      byte_c  = head_i.first ^ key_byte;
      last_c  = 1'b1;
    end else begin
      key_sel = key_ofs[1:0];
      last_c  = (idx_q == key_start + KEY_LAST_OFS);
      if (idx_q == IDX_FIRST) begin
        byte_c = head_i.first;
      end else if (idx_q == IDX_LEN_CODE) begin
        byte_c = {MASK_BIT, len_code};
      end else if (idx_q < key_start) begin
        byte_c = len_byte;
      end else begin
        byte_c = key_byte;
      end
    end
  end

  // The output register loads whenever an entry waits and it is empty or draining.
  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && last_c;

  always_comb begin
    idx_d      = idx_q;
    mask_pos_d = mask_pos_q;
    if (load) begin
      idx_d = last_c ? '0 : idx_q + 1'b1;
    end
    if (pop_o) begin
      mask_pos_d = (head_i.kind == KIND_DATA) ? mask_pos_q + 1'b1 : 2'd0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_key_q  <= '0;
      mask_pos_q  <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mask_key_q <= cfg_mask_key_i;
      end
      mask_pos_q  <= mask_pos_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_c;
      out_last_q <= last_c;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/websocket_frame_encoder.sv -----
// Top level of the client-side WebSocket frame encoder: front end, item queue
// and masking back end. Depends on wsfe_pkg, wsfe_front, wsfe_queue, wsfe_back.
`timescale 1ns / 1ps
`default_nettype none

// Serializes client frames: a header item (op 0) produces 6, 8 or 14 bytes
// (short, 16-bit or 64-bit length form), ending with the four mask-key bytes,
// and restarts the mask position; a payload item (op 1) produces one masked
// byte. A single output register gives one byte (one payload item) per cycle
// while out_stall_i is low; a header item holds it until all its bytes are out.
// A four-entry queue holds classified items so input can still be accepted
// while the output works through a header or is stalled. The mask key is taken
// on any cycle with cfg_valid_i high (cfg_ready_o is always high) and must only
// be written while the block is idle.
module websocket_frame_encoder
  import wsfe_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [KEY_W-1:0] cfg_mask_key_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             op_i,
  input  wire logic             fin_i,
  input  wire logic [3:0]       frame_opcode_i,
  input  wire logic [LEN_W-1:0] payload_length_i,
  input  wire logic [7:0]       data_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_of_run_o
);

  logic push;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t push_cmd;
  cmd_t head;

  assign cfg_ready_o = 1'b1;

  wsfe_front u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .fin_i            (fin_i),
    .frame_opcode_i   (frame_opcode_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .full_i           (full),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  wsfe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  wsfe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_mask_key_i (cfg_mask_key_i),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

// ----- rtl/wsfe_checker.sv -----
// Port-level checks for the WebSocket frame encoder, bound to the top level.
// Depends on wsfe_pkg and websocket_frame_encoder.
`timescale 1ns / 1ps
`default_nettype none

module wsfe_checker
  import wsfe_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       last_of_run_o
);

  // A stalled result item keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
                                   && $stable(last_of_run_o))
    else $error("stalled output item changed");

  // The bytes of one header are all queued together, so a run never has gaps.
  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside a multi-byte run");

  // Reset empties the output register and the queue.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("block not idle during reset");

endmodule

bind websocket_frame_encoder wsfe_checker u_wsfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_o    (out_byte_o),
  .last_of_run_o (last_of_run_o)
);

`default_nettype wire
